// File: rtl/core/sdsf_pkg.sv
package sdsf_pkg;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 6;
  localparam int unsigned ArgW   = 32;
  localparam int unsigned FrameN = 8;
  localparam int unsigned BeatW  = $clog2(FrameN);

  // frame constants
  localparam logic [ByteW-1:0] StartBits  = 8'h40;
  localparam logic [ByteW-1:0] Crc0       = 8'h95;
  localparam logic [ByteW-1:0] Crc8       = 8'h87;
  localparam logic [ByteW-1:0] FillByte   = 8'hFF;
  localparam logic [ByteW-1:0] PollLimRst = 8'd10;

  // beat index of the last frame byte sent
  localparam logic [BeatW-1:0] LastBeatStd  = BeatW'(6);
  localparam logic [BeatW-1:0] LastBeatStop = BeatW'(7);

  // commands with special framing
  localparam logic [IndexW-1:0] CmdGoIdle     = 6'd0;
  localparam logic [IndexW-1:0] CmdSendIfCond = 6'd8;
  localparam logic [IndexW-1:0] CmdStopTran   = 6'd12;

  typedef enum logic {
    ACT_ISSUE = 1'b0,
    ACT_RECV  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_IDLE_RX = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  typedef struct packed {
    logic              action;
    logic [IndexW-1:0] cmd_index;
    logic [ArgW-1:0]   argument;
    logic [ByteW-1:0]  rx_byte;
  } in_t;

  typedef struct packed {
    logic             tx_valid;
    logic [ByteW-1:0] tx_byte;
    logic             last;
    logic             resp_valid;
    logic [ByteW-1:0] resp_byte;
    logic [1:0]       status;
  } out_t;

  // work for one request: either a command frame or one single result
  typedef struct packed {
    logic                         is_frame;
    logic [FrameN-1:0][ByteW-1:0] frame;
    logic [BeatW-1:0]             last_beat;
    out_t                         single;
  } job_t;

endpackage

// File: rtl/core/sdsf_decode.sv
module sdsf_decode import sdsf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  input  in_t              req_i,
  input  logic             take_i,
  output job_t             job_o
);

  logic             waiting_q, waiting_d;
  logic [ByteW-1:0] polls_left_q, polls_left_d;
  logic [ByteW-1:0] poll_limit_q;
  logic [ByteW-1:0] crc;
  logic [ByteW-1:0] lim;
  logic             stop_cmd;

  // poll limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= PollLimRst;
    end else if (cfg_we_i) begin
      poll_limit_q <= cfg_wdata_i;
    end
  end

  // frame contents
  always_comb begin
    case (req_i.cmd_index)
      CmdGoIdle:     crc = Crc0;
      CmdSendIfCond: crc = Crc8;
      default:       crc = FillByte;
    endcase
    stop_cmd = (req_i.cmd_index == CmdStopTran);
    lim      = (poll_limit_q == '0) ? ByteW'(1) : poll_limit_q;
  end

  // job and next exchange state
  always_comb begin
    job_o        = '0;
    waiting_d    = waiting_q;
    polls_left_d = polls_left_q;
    job_o.single.last = 1'b1;
    if (req_i.action == ACT_ISSUE) begin
      job_o.is_frame  = 1'b1;
      job_o.frame[0]  = StartBits | {2'b00, req_i.cmd_index};
      job_o.frame[1]  = req_i.argument[31:24];
      job_o.frame[2]  = req_i.argument[23:16];
      job_o.frame[3]  = req_i.argument[15:8];
      job_o.frame[4]  = req_i.argument[7:0];
      job_o.frame[5]  = crc;
      job_o.frame[6]  = FillByte;
      job_o.frame[7]  = FillByte;
      job_o.last_beat = stop_cmd ? LastBeatStop : LastBeatStd;
      waiting_d       = 1'b1;
      polls_left_d    = lim - ByteW'(1);
    end else if (!waiting_q) begin
      job_o.single.status = ST_IDLE_RX;
    end else if (!req_i.rx_byte[ByteW-1]) begin
      job_o.single.resp_valid = 1'b1;
      job_o.single.resp_byte  = req_i.rx_byte;
      job_o.single.status     = ST_OK;
      waiting_d               = 1'b0;
      polls_left_d            = '0;
    end else if (polls_left_q != '0) begin
      job_o.single.tx_valid = 1'b1;
      job_o.single.tx_byte  = FillByte;
      polls_left_d          = polls_left_q - ByteW'(1);
    end else begin
      job_o.single.resp_valid = 1'b1;
      job_o.single.resp_byte  = req_i.rx_byte;
      job_o.single.status     = ST_TIMEOUT;
      waiting_d               = 1'b0;
    end
  end

  // exchange state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q    <= 1'b0;
      polls_left_q <= '0;
    end else if (take_i) begin
      waiting_q    <= waiting_d;
      polls_left_q <= polls_left_d;
    end
  end

endmodule

// File: rtl/core/sdsf_emit.sv
module sdsf_emit import sdsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  job_t job_i,
  output logic free_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic             busy_q;
  job_t             job_q;
  logic [BeatW-1:0] beat_q;
  logic             out_valid_q;
  out_t             out_q;
  out_t             beat;
  logic             beat_fire;
  logic             end_beat;

  assign beat_fire = busy_q && (!out_valid_q || out_ready_i);
  assign end_beat  = beat_fire && (beat_q == job_q.last_beat);
  assign free_o    = !busy_q || end_beat;

  // current result beat
  always_comb begin
    beat = job_q.single;
    if (job_q.is_frame) begin
      beat          = '0;
      beat.tx_valid = 1'b1;
      beat.tx_byte  = job_q.frame[beat_q];
      beat.last     = (beat_q == job_q.last_beat);
    end
  end

  // job holder and beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      beat_q <= '0;
    end else if (end_beat) begin
      busy_q <= 1'b0;
    end else if (beat_fire) begin
      beat_q <= beat_q + BeatW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (beat_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_fire) begin
      out_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/sd_spi_command_framer.sv
// channel   dir  handshake                 payload
// request   in   in_valid_i / in_ready_o   in_data_i (in_t)
// result    out  out_valid_o / out_ready_i out_data_o (out_t)
// config    in   cfg_we_i                  cfg_wdata_i (poll limit)
//
// a command request gives 7 result beats (8 for the stop command), one beat a cycle unless stalled;
// any other request gives a single beat; the output register sets the pace
// requests pass an input register, then decode into a job held by the emitter
// the next job loads at the edge where the previous one sends its last beat
// reset: idle, no exchange pending, poll limit 10
// a stalled result holds the emitter; the input register still takes one request
module sd_spi_command_framer import sdsf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o
);

  logic in_valid_q;
  in_t  in_q;
  logic job_free;
  logic take;
  job_t job;

  assign take       = in_valid_q && job_free;
  assign in_ready_o = !in_valid_q || take;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  sdsf_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (in_q),
    .take_i      (take),
    .job_o       (job)
  );

  sdsf_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .job_i       (job),
    .free_o      (job_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/core/sdsf_checker.sv
module sdsf_checker import sdsf_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input out_t out_data_i
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // a response or timeout ends the request and sends nothing
  a_resp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.resp_valid |-> out_data_i.last && !out_data_i.tx_valid)
    else $error("response beat not final or carries tx byte");

  // unused byte fields read as zero
  a_zero_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.tx_valid || out_data_i.tx_byte == '0)
                 && (out_data_i.resp_valid || out_data_i.resp_byte == '0))
    else $error("byte field nonzero without its valid");

  // only ok status goes with a transmitted byte
  a_tx_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.tx_valid |-> out_data_i.status == ST_OK)
    else $error("tx beat with error status");

endmodule

bind sd_spi_command_framer sdsf_checker u_sdsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
